// ===== src/r2fbf_pkg.sv =====
`timescale 1ns / 1ps
package r2fbf_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
	localparam logic [63:0] HALF_PI_Q60 = PI_Q60 >> 1;
	localparam logic [63:0] Q60_ONE     = 64'h1 << 60;

	// Taylor term divisors: (2n)(2n+1) for sin, (2n-1)(2n) for cos
	localparam logic [63:0] SIN_DEN [1:16] = '{
		64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156, 64'd210,  64'd272,
		64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930, 64'd1056
	};
	localparam logic [63:0] COS_DEN [1:16] = '{
		64'd2,   64'd12,  64'd30,  64'd56,  64'd90,  64'd132, 64'd182, 64'd240,
		64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756, 64'd870, 64'd992
	};

	function automatic logic [63:0] q60_mul(input logic [63:0] x, input logic [63:0] y);
		logic [127:0] p;
		p = {64'd0, x} * {64'd0, y};
		return p[123:60];
	endfunction

	function automatic logic [63:0] q60_round(input logic [63:0] v, input int frac);
		logic [63:0] m;
		m = v[63] ? 64'd0 : v;
		return (m + (64'd1 << (59 - frac))) >> (60 - frac);
	endfunction

	// {cos, -sin} of a Q60 angle in [0, pi), each rounded to frac fraction bits
	function automatic logic [127:0] twiddle_q(input logic [63:0] angle, input int frac);
		logic [63:0] th;
		logic [63:0] th2;
		logic [63:0] s;
		logic [63:0] c;
		logic [63:0] ts;
		logic [63:0] tc;
		logic [63:0] cv;
		logic [63:0] sv;
		logic        flip;
		th   = angle;
		flip = 1'b0;
		if (th > HALF_PI_Q60) begin
			th   = PI_Q60 - th;
			flip = 1'b1;
		end
		th2 = q60_mul(th, th);
		s   = th;
		ts  = th;
		c   = Q60_ONE;
		tc  = Q60_ONE;
		for (int n = 1; n <= 16; n++) begin
			ts = q60_mul(ts, th2) / SIN_DEN[n];
			tc = q60_mul(tc, th2) / COS_DEN[n];
			if ((n & 1) != 0) begin
				s = s - ts;
				c = c - tc;
			end else begin
				s = s + ts;
				c = c + tc;
			end
		end
		cv = q60_round(c, frac);
		sv = q60_round(s, frac);
		return {(flip ? (64'd0 - cv) : cv), (64'd0 - sv)};
	endfunction

endpackage

// ===== src/r2fbf_queue.sv =====
`timescale 1ns / 1ps
module r2fbf_queue
	import r2fbf_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/r2fbf_front.sv =====
`timescale 1ns / 1ps
module r2fbf_front
	import r2fbf_pkg::*;
#(
	parameter int POINTS       = 64,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pair_valid,
	output logic                           pair_stall,
	input  logic                           last_in,
	input  logic signed [SAMPLE_WIDTH-1:0] a_real,
	input  logic signed [SAMPLE_WIDTH-1:0] a_imag,
	input  logic signed [SAMPLE_WIDTH-1:0] b_real,
	input  logic signed [SAMPLE_WIDTH-1:0] b_imag,
	output logic                           push,
	output logic [4*SAMPLE_WIDTH+((POINTS/2 > 1) ? $clog2(POINTS/2) : 1):0] push_data,
	input  logic                           full
);

	localparam int TW_COUNT = POINTS / 2;
	localparam int IDX_W    = (TW_COUNT > 1) ? $clog2(TW_COUNT) : 1;

	logic [IDX_W-1:0] idx_q;

	assign pair_stall = full;
	assign push       = pair_valid && !full;
	assign push_data  = {last_in, a_real, a_imag, b_real, b_imag, idx_q};

	// twiddle index: restarts on last word of a frame or at the table end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (push) begin
			if (last_in || (idx_q == IDX_W'(TW_COUNT - 1))) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

endmodule

// ===== src/r2fbf_back.sv =====
`timescale 1ns / 1ps
module r2fbf_back
	import r2fbf_pkg::*;
#(
	parameter int POINTS                = 64,
	parameter int SAMPLE_WIDTH          = 16,
	parameter int TWIDDLE_FRACTION_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pop_valid,
	input  logic [4*SAMPLE_WIDTH+((POINTS/2 > 1) ? $clog2(POINTS/2) : 1):0] pop_data,
	output logic                             pop,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic                             last_out,
	output logic signed [SAMPLE_WIDTH+1:0]   sum_real,
	output logic signed [SAMPLE_WIDTH+1:0]   sum_imag,
	output logic signed [SAMPLE_WIDTH+1:0]   diff_real,
	output logic signed [SAMPLE_WIDTH+1:0]   diff_imag
);

	localparam int TW_COUNT = POINTS / 2;
	localparam int IDX_W    = (TW_COUNT > 1) ? $clog2(TW_COUNT) : 1;
	localparam int SW       = SAMPLE_WIDTH;
	localparam int FRAC     = TWIDDLE_FRACTION_BITS;
	localparam int TW_W     = FRAC + 2;
	localparam int PW       = SW + TW_W;
	localparam int OW       = SW + 2;
	localparam logic signed [PW+1:0] RND = (PW + 2)'(1) <<< (FRAC - 1);

	// twiddle ROM
	logic signed [TW_W-1:0] cos_rom  [TW_COUNT];
	logic signed [TW_W-1:0] nsin_rom [TW_COUNT];

	for (genvar k = 0; k < TW_COUNT; k++) begin : g_rom
		localparam logic [63:0] ANG = (PI_Q60 / 64'(POINTS)) * 64'(2 * k)
			+ ((PI_Q60 % 64'(POINTS)) * 64'(2 * k)) / 64'(POINTS);
		localparam logic [127:0] TW = twiddle_q(ANG, FRAC);
		assign cos_rom[k]  = TW[64 +: TW_W];
		assign nsin_rom[k] = TW[0 +: TW_W];
	end

	logic                   en;
	logic                   in_last;
	logic signed [SW-1:0]   in_ar;
	logic signed [SW-1:0]   in_ai;
	logic signed [SW-1:0]   in_br;
	logic signed [SW-1:0]   in_bi;
	logic [IDX_W-1:0]       in_idx;

	logic                   valid_s1;
	logic                   last_s1;
	logic signed [SW-1:0]   ar_s1;
	logic signed [SW-1:0]   ai_s1;
	logic signed [SW-1:0]   br_s1;
	logic signed [SW-1:0]   bi_s1;
	logic signed [TW_W-1:0] wr_s1;
	logic signed [TW_W-1:0] wi_s1;

	logic                   valid_s2;
	logic                   last_s2;
	logic signed [SW-1:0]   ar_s2;
	logic signed [SW-1:0]   ai_s2;
	logic signed [PW-1:0]   rr_s2;
	logic signed [PW-1:0]   ii_s2;
	logic signed [PW-1:0]   ri_s2;
	logic signed [PW-1:0]   ir_s2;

	logic                   valid_s3;
	logic                   last_s3;
	logic signed [SW-1:0]   ar_s3;
	logic signed [SW-1:0]   ai_s3;
	logic signed [OW-1:0]   pr_s3;
	logic signed [OW-1:0]   pi_s3;

	logic                   valid_s4;
	logic                   last_s4;
	logic signed [OW-1:0]   sr_s4;
	logic signed [OW-1:0]   si_s4;
	logic signed [OW-1:0]   dr_s4;
	logic signed [OW-1:0]   di_s4;

	logic signed [PW+1:0]   re_full;
	logic signed [PW+1:0]   im_full;

	assign {in_last, in_ar, in_ai, in_br, in_bi, in_idx} = pop_data;

	assign en  = !valid_s4 || !result_stall;
	assign pop = en;

	// exact products, round half up, drop fraction bits
	always_comb begin
		re_full = (PW + 2)'(rr_s2) - (PW + 2)'(ii_s2) + RND;
		im_full = (PW + 2)'(ri_s2) + (PW + 2)'(ir_s2) + RND;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pop_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= in_last;
			ar_s1   <= in_ar;
			ai_s1   <= in_ai;
			br_s1   <= in_br;
			bi_s1   <= in_bi;
			wr_s1   <= cos_rom[in_idx];
			wi_s1   <= nsin_rom[in_idx];

			last_s2 <= last_s1;
			ar_s2   <= ar_s1;
			ai_s2   <= ai_s1;
			rr_s2   <= PW'(br_s1) * PW'(wr_s1);
			ii_s2   <= PW'(bi_s1) * PW'(wi_s1);
			ri_s2   <= PW'(br_s1) * PW'(wi_s1);
			ir_s2   <= PW'(bi_s1) * PW'(wr_s1);

			last_s3 <= last_s2;
			ar_s3   <= ar_s2;
			ai_s3   <= ai_s2;
			pr_s3   <= OW'(re_full >>> FRAC);
			pi_s3   <= OW'(im_full >>> FRAC);

			last_s4 <= last_s3;
			sr_s4   <= OW'(ar_s3) + pr_s3;
			si_s4   <= OW'(ai_s3) + pi_s3;
			dr_s4   <= OW'(ar_s3) - pr_s3;
			di_s4   <= OW'(ai_s3) - pi_s3;
		end
	end

	assign result_valid = valid_s4;
	assign last_out     = last_s4;
	assign sum_real     = sr_s4;
	assign sum_imag     = si_s4;
	assign diff_real    = dr_s4;
	assign diff_imag    = di_s4;

endmodule

// ===== src/radix2_fft_stage_butterfly_top.sv =====
`timescale 1ns / 1ps
// Streaming butterfly for one decimation-in-time FFT stage.
// Input channel (pair_valid / pair_stall): one word carries samples a and b
// and last_in. Output channel (result_valid / result_stall): one word
// carries a + b*W, a - b*W and last_out.
// b is rotated by W[k] = cos(2*pi*k/POINTS) - j*sin(2*pi*k/POINTS), taken
// from a constant ROM of POINTS/2 entries. k starts at 0, steps once per
// accepted word and returns to 0 after a word with last_in set or after
// the final ROM entry.
// Throughput: one word per clock while result_stall is low. An accepted
// word lands in the 4-entry input queue, then moves through the back
// pipeline stages in order: ROM read, multiply, round, add/sub; the
// add/sub stage drives result_valid.
// When result_stall is high the back pipeline holds; the queue keeps taking
// words until it is full, then pair_stall rises.
// Reset (arst_n low) empties queue and pipeline and sets k to 0.
module radix2_fft_stage_butterfly_top
	import r2fbf_pkg::*;
#(
	parameter int POINTS                = 64,
	parameter int SAMPLE_WIDTH          = 16,
	parameter int TWIDDLE_FRACTION_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pair_valid,
	output logic                           pair_stall,
	input  logic                           last_in,
	input  logic signed [SAMPLE_WIDTH-1:0] a_real,
	input  logic signed [SAMPLE_WIDTH-1:0] a_imag,
	input  logic signed [SAMPLE_WIDTH-1:0] b_real,
	input  logic signed [SAMPLE_WIDTH-1:0] b_imag,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic                           last_out,
	output logic signed [SAMPLE_WIDTH+1:0] sum_real,
	output logic signed [SAMPLE_WIDTH+1:0] sum_imag,
	output logic signed [SAMPLE_WIDTH+1:0] diff_real,
	output logic signed [SAMPLE_WIDTH+1:0] diff_imag
);

	localparam int TW_COUNT = POINTS / 2;
	localparam int IDX_W    = (TW_COUNT > 1) ? $clog2(TW_COUNT) : 1;
	localparam int EW       = 1 + 4 * SAMPLE_WIDTH + IDX_W;

	logic          push;
	logic [EW-1:0] push_data;
	logic          full;
	logic          pop;
	logic          pop_valid;
	logic [EW-1:0] pop_data;

	r2fbf_front #(
		.POINTS       (POINTS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair_valid),
		.pair_stall (pair_stall),
		.last_in    (last_in),
		.a_real     (a_real),
		.a_imag     (a_imag),
		.b_real     (b_real),
		.b_imag     (b_imag),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	r2fbf_queue #(
		.WIDTH (EW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	r2fbf_back #(
		.POINTS                (POINTS),
		.SAMPLE_WIDTH          (SAMPLE_WIDTH),
		.TWIDDLE_FRACTION_BITS (TWIDDLE_FRACTION_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_data     (pop_data),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.last_out     (last_out),
		.sum_real     (sum_real),
		.sum_imag     (sum_imag),
		.diff_real    (diff_real),
		.diff_imag    (diff_imag)
	);

endmodule

// ===== dv/butterfly_board_pkg.sv =====
`timescale 1ns / 1ps
package butterfly_board_pkg;

	localparam int POINTS     = 64;
	localparam int SW         = 16;
	localparam int FRAC       = 16;
	localparam int TW_ENTRIES = POINTS / 2;
	localparam int IDX_W      = $clog2(TW_ENTRIES);
	localparam int OUT_W      = SW + 2;

	localparam logic [63:0] PI_FIX   = 64'h3243F6A8885A308D;
	localparam logic [63:0] UNIT_FIX = 64'h1 << 60;

	typedef struct {
		logic                 last;
		logic signed [SW-1:0] a_real;
		logic signed [SW-1:0] a_imag;
		logic signed [SW-1:0] b_real;
		logic signed [SW-1:0] b_imag;
	} pair_t;

	typedef struct {
		logic                    last;
		logic signed [OUT_W-1:0] sum_real;
		logic signed [OUT_W-1:0] sum_imag;
		logic signed [OUT_W-1:0] diff_real;
		logic signed [OUT_W-1:0] diff_imag;
	} result_t;

	class butterfly_board;
		longint            rot_re [TW_ENTRIES];
		longint            rot_im [TW_ENTRIES];
		logic [IDX_W-1:0]  tw_index;
		result_t           pending [$];
		int                fails = 0;
		int                checked = 0;
		int                frame_ends = 0;
		int                table_wraps = 0;

		function new();
			build_rotations();
			tw_index = '0;
		endfunction

		// Q60 x Q60 -> Q60, truncated
		function logic [63:0] mul_fix(logic [63:0] x, logic [63:0] y);
			logic [127:0] full;
			full = {64'd0, x} * {64'd0, y};
			return 64'(full >> 60);
		endfunction

		// Q60 magnitude to FRAC fraction bits, halves away from zero
		function longint round_fix(logic [63:0] v);
			if (v[63])
				v = '0;
			return longint'((v + (64'd1 << (59 - FRAC))) >> (60 - FRAC));
		endfunction

		function void build_rotations();
			logic [63:0] span;
			logic [63:0] ang;
			logic [63:0] ang_sq;
			logic [63:0] s;
			logic [63:0] c;
			logic [63:0] ts;
			logic [63:0] tc;
			logic        mirror;
			for (int k = 0; k < TW_ENTRIES; k++) begin
				span = 64'(2 * k);
				ang = (PI_FIX / 64'(POINTS)) * span
					+ ((PI_FIX % 64'(POINTS)) * span) / 64'(POINTS);
				mirror = ang > (PI_FIX >> 1);
				if (mirror)
					ang = PI_FIX - ang;
				ang_sq = mul_fix(ang, ang);
				s = ang;
				ts = ang;
				c = UNIT_FIX;
				tc = UNIT_FIX;
				for (int n = 1; n <= 16; n++) begin
					ts = mul_fix(ts, ang_sq) / 64'((2 * n) * (2 * n + 1));
					tc = mul_fix(tc, ang_sq) / 64'((2 * n - 1) * (2 * n));
					if (n % 2 == 1) begin
						s = s - ts;
						c = c - tc;
					end else begin
						s = s + ts;
						c = c + tc;
					end
				end
				rot_re[IDX_W'(k)] = mirror ? -round_fix(c) : round_fix(c);
				rot_im[IDX_W'(k)] = -round_fix(s);
			end
		endfunction

		// round to nearest, halves up, drop fraction bits
		function longint drop_frac(longint x);
			return (x + (longint'(1) << (FRAC - 1))) >>> FRAC;
		endfunction

		function void predict_butterfly(pair_t p);
			logic [IDX_W-1:0] idx;
			longint  ar;
			longint  ai;
			longint  br;
			longint  bi;
			longint  pr;
			longint  pim;
			result_t r;
			idx = tw_index;
			ar = p.a_real;
			ai = p.a_imag;
			br = p.b_real;
			bi = p.b_imag;
			pr = drop_frac(br * rot_re[idx] - bi * rot_im[idx]);
			pim = drop_frac(br * rot_im[idx] + bi * rot_re[idx]);
			r.last = p.last;
			r.sum_real = OUT_W'(ar + pr);
			r.sum_imag = OUT_W'(ai + pim);
			r.diff_real = OUT_W'(ar - pr);
			r.diff_imag = OUT_W'(ai - pim);
			pending.push_back(r);
			if (p.last || idx >= IDX_W'(TW_ENTRIES - 1)) begin
				if (p.last)
					frame_ends++;
				else
					table_wraps++;
				tw_index = '0;
			end else begin
				tw_index = idx + IDX_W'(1);
			end
		endfunction

		task report(string what);
			fails++;
			$display("ERROR: %s", what);
		endtask

		task field_check(string name, logic signed [63:0] got_v, logic signed [63:0] want_v);
			if (got_v !== want_v)
				report($sformatf("result %0d %s: got %0d, want %0d",
					checked, name, got_v, want_v));
		endtask

		task check_butterfly(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				report($sformatf("result with no pair pending: sum (%0d,%0d) diff (%0d,%0d)",
					got.sum_real, got.sum_imag, got.diff_real, got.diff_imag));
				return;
			end
			want = pending.pop_front();
			field_check("last_out", {63'd0, got.last}, {63'd0, want.last});
			field_check("sum_real", got.sum_real, want.sum_real);
			field_check("sum_imag", got.sum_imag, want.sum_imag);
			field_check("diff_real", got.diff_real, want.diff_real);
			field_check("diff_imag", got.diff_imag, want.diff_imag);
			checked++;
		endtask
	endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import butterfly_board_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int PHASE_PAIRS = 332;
	localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [SW-1:0] S_ONE = SW'(1);
	localparam logic signed [SW-1:0] S_NEG = SW'(-1);

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b1;
	logic                    pair_valid = 1'b0;
	logic                    pair_stall;
	logic                    last_in = 1'b0;
	logic signed [SW-1:0]    a_real = '0;
	logic signed [SW-1:0]    a_imag = '0;
	logic signed [SW-1:0]    b_real = '0;
	logic signed [SW-1:0]    b_imag = '0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic                    last_out;
	logic signed [OUT_W-1:0] sum_real;
	logic signed [OUT_W-1:0] sum_imag;
	logic signed [OUT_W-1:0] diff_real;
	logic signed [OUT_W-1:0] diff_imag;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_asked = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int pairs_sent = 0;

	butterfly_board board = new();
	logic signed [SW-1:0] corner [4] = '{S_MIN, S_MAX, '0, S_NEG};

	radix2_fft_stage_butterfly_top #(
		.POINTS(POINTS),
		.SAMPLE_WIDTH(SW),
		.TWIDDLE_FRACTION_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pair_valid(pair_valid),
		.pair_stall(pair_stall),
		.last_in(last_in),
		.a_real(a_real),
		.a_imag(a_imag),
		.b_real(b_real),
		.b_imag(b_imag),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.last_out(last_out),
		.sum_real(sum_real),
		.sum_imag(sum_imag),
		.diff_real(diff_real),
		.diff_imag(diff_imag)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic pair_t make_pair(logic lst, logic signed [SW-1:0] ar,
		logic signed [SW-1:0] ai, logic signed [SW-1:0] br, logic signed [SW-1:0] bi);
		pair_t p;
		p.last = lst;
		p.a_real = ar;
		p.a_imag = ai;
		p.b_real = br;
		p.b_imag = bi;
		return p;
	endfunction

	function automatic logic signed [SW-1:0] random_sample();
		case ($urandom_range(9))
			0: return S_MIN;
			1: return S_MAX;
			2: return '0;
			default: return SW'($urandom);
		endcase
	endfunction

	// called at an edge where the previous word (if any) was just taken
	task automatic send_pair(pair_t p);
		int gap;
		gap = 0;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			pair_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pair_valid <= 1'b1;
		last_in <= p.last;
		a_real <= p.a_real;
		a_imag <= p.a_imag;
		b_real <= p.b_real;
		b_imag <= p.b_imag;
		do
			@(posedge clk);
		while (pair_stall);
		board.predict_butterfly(p);
		pairs_sent++;
	endtask

	// mostly whole frames; some short or overlong frames, some runs with stray last flags
	task automatic send_frame();
		int   kind;
		int   len;
		logic lst;
		kind = $urandom_range(9);
		if (kind <= 6)
			len = TW_ENTRIES;
		else if (kind <= 8)
			len = $urandom_range(40, 1);
		else
			len = $urandom_range(80, 33);
		for (int i = 0; i < len; i++) begin
			if (kind == 9)
				lst = ($urandom_range(15) == 0);
			else
				lst = (i == len - 1);
			send_pair(make_pair(lst, random_sample(), random_sample(),
				random_sample(), random_sample()));
		end
	endtask

	task automatic drain();
		pair_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	// output side
	initial begin
		result_t seen;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				seen.last = last_out;
				seen.sum_real = sum_real;
				seen.sum_imag = sum_imag;
				seen.diff_real = diff_real;
				seen.diff_imag = diff_imag;
				board.check_butterfly(seen);
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (hold_taken != hold_asked) begin
				hold_taken++;
				hold_left = HOLD_CYCLES - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	initial begin
		int stale;
		stale = 0;
		while (stale < STALL_LIMIT) begin
			@(posedge clk);
			if ((pair_valid && !pair_stall) || (result_valid && !result_stall))
				stale = 0;
			else
				stale++;
		end
		$display("FAIL radix2_fft_stage_butterfly_top");
		$finish;
	end

	initial begin
		int goal;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, last flag mid-table, walk past the quarter-turn entry
		send_pair(make_pair(1'b0, '0, '0, '0, '0));
		send_pair(make_pair(1'b0, S_MAX, S_MAX, S_MAX, S_MAX));
		send_pair(make_pair(1'b0, S_MIN, S_MIN, S_MIN, S_MIN));
		send_pair(make_pair(1'b0, S_MAX, S_MIN, S_MIN, S_MAX));
		send_pair(make_pair(1'b0, S_MIN, S_MAX, S_MAX, S_MIN));
		send_pair(make_pair(1'b0, S_NEG, S_ONE, S_ONE, S_NEG));
		send_pair(make_pair(1'b1, S_MAX, S_MAX, S_MIN, S_MIN));
		for (int i = 0; i < 18; i++)
			send_pair(make_pair(i == 17, corner[2'(i % 4)], corner[2'((i + 1) % 4)],
				corner[2'((i / 2) % 4)], corner[2'((i + 3) % 4)]));
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					hold_asked++;
				end
				1: begin
					send_idle_pct = 88;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 88;
				end
				default: begin
					send_idle_pct = 14;
					recv_stall_pct = 14;
				end
			endcase
			goal = pairs_sent + PHASE_PAIRS;
			while (pairs_sent < goal)
				send_frame();
			drain();
		end

		repeat (12) @(posedge clk);
		$display("Checked %0d results from %0d sample pairs: %0d frame ends, %0d bare table wraps.",
			board.checked, pairs_sent, board.frame_ends, board.table_wraps);
		$display("Phases: extremes, free-running, idle input, stalled output, mixed; %0d-cycle hold.",
			HOLD_CYCLES);
		if (board.fails == 0)
			$display("PASS radix2_fft_stage_butterfly_top");
		else
			$display("FAIL radix2_fft_stage_butterfly_top");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/r2fbf_pkg.sv
src/r2fbf_queue.sv
src/r2fbf_front.sv
src/r2fbf_back.sv
src/radix2_fft_stage_butterfly_top.sv
dv/butterfly_board_pkg.sv
dv/tb_top.sv
